// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_AT(label, clock, reset_n, prop) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) \
        else $error("assertion failed");

// condition implies property in the following cycle
`define ASSERT_NEXT(label, clock, reset_n, cond, prop) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ===== hdl/blpo_pkg.sv =====
// ----------------------------------------------------------------------------
// blpo_pkg
// constants and types of the band limited partial oscillator
// ----------------------------------------------------------------------------
package blpo_pkg;

    localparam logic [2:0] REG_WAVE      = 3'd0;
    localparam logic [2:0] REG_GAIN      = 3'd1;
    localparam logic [2:0] REG_OFFSET    = 3'd2;
    localparam logic [2:0] REG_HB_ENABLE = 3'd3;
    localparam logic [2:0] REG_HB_THRESH = 3'd4;
    localparam logic [2:0] REG_HB_GAIN   = 3'd5;
    localparam logic [2:0] REG_DRIVE     = 3'd6;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_CLAMP    = 3'd4;

    localparam logic signed [26:0] Q24_ONE  = 27'sd16777216;
    localparam logic [23:0]        PH_HALF  = 24'h800000;
    localparam logic [23:0]        PH_QUART = 24'h400000;

    typedef struct packed {
        logic [23:0] r;
        logic [23:0] q;
    } div_t;

endpackage

// ===== hdl/band_limited_partial_oscillator.sv =====
// ----------------------------------------------------------------------------
// band_limited_partial_oscillator
// one partial sample per request: sine table, triangle, polyblep saw and
// square, driven and clamped sine, gain with high band scaling
// ----------------------------------------------------------------------------
// Takes one request per clock unless a stalled output has filled every stage.
// The latency is set by the polyblep quotient, a restoring divider cut into 12
// stages of two bits each, with a squaring multiplier, waveform select, gain
// multiplier and saturation behind it. The sine table is a constant memory
// built at elaboration, read with a registered read. Stalled stages hold, and
// empty stages fill while the output waits.

module band_limited_partial_oscillator #(
    parameter int SINE_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [23:0] phase_turns,
    input  logic [19:0] tone_frequency,
    input  logic [23:0] phase_step,
    output logic        sample_valid,
    input  logic        sample_ready,
    output logic signed [15:0] sample_out
);

    localparam int AW = $clog2(SINE_ENTRIES);
    localparam int NW = $clog2(SINE_ENTRIES + 1);
    localparam int IW = 24 + NW;
    localparam int NS = 17;
    localparam int DIV_FIRST = 1;
    localparam int DIV_LAST = 12;
    localparam int S_ROM = 2;

    typedef logic signed [15:0] rom_t [SINE_ENTRIES];

    typedef struct packed {
        logic [23:0]        p;
        logic [2:0]         wsel;
        logic               hb;
        logic signed [17:0] gain;
        logic [23:0]        dt;
        logic [23:0]        ra;
        logic [23:0]        qa;
        logic               acta;
        logic               c1a;
        logic [23:0]        rb;
        logic [23:0]        qb;
        logic               actb;
        logic               c1b;
        logic [AW-1:0]      a;
        logic [23:0]        frac;
        logic signed [15:0] va;
        logic signed [41:0] sprod;
        logic signed [26:0] ws;
        logic signed [43:0] dprod;
        logic [47:0]        tta;
        logic [47:0]        ttb;
        logic signed [26:0] w;
        logic signed [44:0] yprod;
        logic signed [15:0] y;
    } stage_t;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic rom_t build_rom();
        rom_t        tab;
        longint      t;
        longint      u;
        longint      f;
        longint      f2;
        longint      r;
        longint      s;
        longint      q;
        int          quad;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            t = (longint'(i) <<< 32) / SINE_ENTRIES;
            quad = int'((t >>> 30) & 3);
            u = t & 64'h3FFFFFFF;
            if ((quad & 1) != 0)
            begin
                u = 64'h40000000 - u;
            end
            f = u;
            f2 = round_shift(f * f, 30);
            r = 3864;
            r = 172272 - round_shift(r * f2, 30);
            r = 5026994 - round_shift(r * f2, 30);
            r = 85569306 - round_shift(r * f2, 30);
            r = 693598669 - round_shift(r * f2, 30);
            r = 1686629713 - round_shift(r * f2, 30);
            s = round_shift(r * f, 30);
            q = round_shift(s, 15);
            if (q > 32767)
            begin
                q = 32767;
            end
            if (q < 0)
            begin
                q = 0;
            end
            tab[i] = 16'((quad >= 2) ? -q : q);
        end
        return tab;
    endfunction

    function automatic blpo_pkg::div_t div_step(blpo_pkg::div_t x, logic [23:0] d);
        blpo_pkg::div_t y;
        logic [24:0]    r2;
        r2 = {x.r, 1'b0};
        if (r2 >= {1'b0, d})
        begin
            y.r = 24'(r2 - {1'b0, d});
            y.q = {x.q[22:0], 1'b1};
        end
        else
        begin
            y.r = r2[23:0];
            y.q = {x.q[22:0], 1'b0};
        end
        return y;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration registers
    logic [2:0]         waveform_select_reg;
    logic signed [15:0] partial_gain_reg;
    logic [23:0]        phase_offset_turns_reg;
    logic               high_band_enable_reg;
    logic [19:0]        high_band_threshold_reg;
    logic signed [15:0] high_band_gain_reg;
    logic [15:0]        sine_drive_reg;
    logic signed [17:0] hb_gain_reg;
    logic signed [31:0] hb_prod;
    logic               cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign hb_prod = partial_gain_reg * high_band_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_select_reg     <= blpo_pkg::WAVE_SINE;
            partial_gain_reg        <= 16'sd16384;
            phase_offset_turns_reg  <= '0;
            high_band_enable_reg    <= 1'b0;
            high_band_threshold_reg <= '0;
            high_band_gain_reg      <= 16'sd16384;
            sine_drive_reg          <= 16'd4096;
            hb_gain_reg             <= 18'sd16384;
        end
        else
        begin
            hb_gain_reg <= 18'((33'(hb_prod) + 33'sd8192) >>> 14);
            if (cfg_write)
            begin
                unique case (paddr[4:2])
                    blpo_pkg::REG_WAVE:      waveform_select_reg     <= pwdata[2:0];
                    blpo_pkg::REG_GAIN:      partial_gain_reg        <= pwdata[15:0];
                    blpo_pkg::REG_OFFSET:    phase_offset_turns_reg  <= pwdata[23:0];
                    blpo_pkg::REG_HB_ENABLE: high_band_enable_reg    <= pwdata[0];
                    blpo_pkg::REG_HB_THRESH: high_band_threshold_reg <= pwdata[19:0];
                    blpo_pkg::REG_HB_GAIN:   high_band_gain_reg      <= pwdata[15:0];
                    blpo_pkg::REG_DRIVE:     sine_drive_reg          <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            blpo_pkg::REG_WAVE:      prdata = {29'd0, waveform_select_reg};
            blpo_pkg::REG_GAIN:      prdata = {16'd0, partial_gain_reg};
            blpo_pkg::REG_OFFSET:    prdata = {8'd0, phase_offset_turns_reg};
            blpo_pkg::REG_HB_ENABLE: prdata = {31'd0, high_band_enable_reg};
            blpo_pkg::REG_HB_THRESH: prdata = {12'd0, high_band_threshold_reg};
            blpo_pkg::REG_HB_GAIN:   prdata = {16'd0, high_band_gain_reg};
            blpo_pkg::REG_DRIVE:     prdata = {16'd0, sine_drive_reg};
            default:                 prdata = '0;
        endcase
    end

    // pipeline
    stage_t             pipe_reg [NS];
    stage_t             pipe_next [NS];
    logic [NS-1:0]      v_reg;
    logic [NS-1:0]      en;
    logic signed [15:0] va_reg;
    logic signed [15:0] vb_reg;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || sample_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign item_ready = en[0];
    assign sample_valid = v_reg[NS-1];
    assign sample_out = pipe_reg[NS-1].y;

    always_comb
    begin
        logic [23:0]        p;
        logic [23:0]        p2;
        logic [23:0]        dtc;
        logic [IW-1:0]      idx;
        logic signed [16:0] diff;
        logic signed [43:0] rnd;
        logic signed [26:0] tq;
        logic signed [26:0] t2a;
        logic signed [26:0] t2b;
        logic signed [26:0] hqa;
        logic signed [26:0] hqb;
        logic signed [26:0] blep_a;
        logic signed [26:0] blep_b;
        logic [24:0]        dd;
        logic signed [44:0] yr;
        blpo_pkg::div_t     da;
        blpo_pkg::div_t     db;

        for (int k = 1; k < NS; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end

        // request capture
        pipe_next[0] = pipe_reg[0];
        p = phase_turns + phase_offset_turns_reg;
        p2 = p + blpo_pkg::PH_HALF;
        dtc = (phase_step > blpo_pkg::PH_HALF) ? blpo_pkg::PH_HALF : phase_step;
        pipe_next[0].p = p;
        pipe_next[0].dt = dtc;
        pipe_next[0].wsel = waveform_select_reg;
        pipe_next[0].hb = high_band_enable_reg && (tone_frequency >= high_band_threshold_reg);
        pipe_next[0].gain = 18'(partial_gain_reg);
        pipe_next[0].c1a = p < dtc;
        pipe_next[0].acta = (dtc != '0) && ((p < dtc) || ({1'b0, p} > 25'h1000000 - dtc));
        pipe_next[0].ra = (p < dtc) ? p : 24'(25'h1000000 - {1'b0, p});
        pipe_next[0].qa = '0;
        pipe_next[0].c1b = p2 < dtc;
        pipe_next[0].actb = (dtc != '0) && ((p2 < dtc) || ({1'b0, p2} > 25'h1000000 - dtc));
        pipe_next[0].rb = (p2 < dtc) ? p2 : 24'(25'h1000000 - {1'b0, p2});
        pipe_next[0].qb = '0;

        // high band gain select
        if (pipe_reg[0].hb)
        begin
            pipe_next[1].gain = hb_gain_reg;
        end

        // polyblep quotients, two bits per stage
        for (int k = DIV_FIRST; k <= DIV_LAST; k++)
        begin
            da = div_step(div_step({pipe_reg[k-1].ra, pipe_reg[k-1].qa}, pipe_reg[k-1].dt),
                          pipe_reg[k-1].dt);
            db = div_step(div_step({pipe_reg[k-1].rb, pipe_reg[k-1].qb}, pipe_reg[k-1].dt),
                          pipe_reg[k-1].dt);
            pipe_next[k].ra = da.r;
            pipe_next[k].qa = da.q;
            pipe_next[k].rb = db.r;
            pipe_next[k].qb = db.q;
        end

        // sine table index and fraction
        idx = IW'(pipe_reg[0].p) * IW'(SINE_ENTRIES);
        pipe_next[1].a = idx[24 +: AW];
        pipe_next[1].frac = idx[23:0];

        // interpolation
        diff = 17'(vb_reg) - 17'(va_reg);
        pipe_next[3].va = va_reg;
        pipe_next[3].sprod = diff * $signed({1'b0, pipe_reg[2].frac});
        pipe_next[4].ws = $signed({{2{pipe_reg[3].va[15]}}, pipe_reg[3].va, 9'd0})
            + 27'(pipe_reg[3].sprod >>> 15);

        // drive and clamp
        pipe_next[5].dprod = pipe_reg[4].ws * $signed({1'b0, sine_drive_reg});
        rnd = (pipe_reg[5].dprod + 44'sd2048) >>> 12;
        if (pipe_reg[5].wsel == blpo_pkg::WAVE_CLAMP)
        begin
            if (rnd > 44'(blpo_pkg::Q24_ONE))
            begin
                pipe_next[6].ws = blpo_pkg::Q24_ONE;
            end
            else if (rnd < -44'(blpo_pkg::Q24_ONE))
            begin
                pipe_next[6].ws = -blpo_pkg::Q24_ONE;
            end
            else
            begin
                pipe_next[6].ws = 27'(rnd);
            end
        end

        // squares of the quotients
        pipe_next[13].tta = 48'(pipe_reg[12].qa) * 48'(pipe_reg[12].qa);
        pipe_next[13].ttb = 48'(pipe_reg[12].qb) * 48'(pipe_reg[12].qb);

        // waveform select
        t2a = $signed({2'b0, pipe_reg[13].qa, 1'b0});
        t2b = $signed({2'b0, pipe_reg[13].qb, 1'b0});
        hqa = $signed({3'b0, pipe_reg[13].tta[47:24]});
        hqb = $signed({3'b0, pipe_reg[13].ttb[47:24]});
        if (!pipe_reg[13].acta)
        begin
            blep_a = '0;
        end
        else if (pipe_reg[13].c1a)
        begin
            blep_a = t2a - hqa - blpo_pkg::Q24_ONE;
        end
        else
        begin
            blep_a = hqa - t2a + blpo_pkg::Q24_ONE;
        end
        if (!pipe_reg[13].actb)
        begin
            blep_b = '0;
        end
        else if (pipe_reg[13].c1b)
        begin
            blep_b = t2b - hqb - blpo_pkg::Q24_ONE;
        end
        else
        begin
            blep_b = hqb - t2b + blpo_pkg::Q24_ONE;
        end
        p = pipe_reg[13].p - blpo_pkg::PH_QUART;
        dd = p[23] ? 25'h1000000 - {1'b0, p} : {1'b0, p};
        tq = blpo_pkg::Q24_ONE - $signed({dd, 2'b0});
        case (pipe_reg[13].wsel)
            blpo_pkg::WAVE_TRIANGLE: pipe_next[14].w = tq;
            blpo_pkg::WAVE_SAW:
                pipe_next[14].w = $signed({2'b0, pipe_reg[13].p, 1'b0})
                    - blpo_pkg::Q24_ONE - blep_a;
            blpo_pkg::WAVE_SQUARE:
                pipe_next[14].w = (pipe_reg[13].p[23] ? -blpo_pkg::Q24_ONE : blpo_pkg::Q24_ONE)
                    + blep_a - blep_b;
            default: pipe_next[14].w = pipe_reg[13].ws;
        endcase

        // gain and saturation
        pipe_next[15].yprod = pipe_reg[14].w * pipe_reg[14].gain;
        yr = (pipe_reg[15].yprod + 45'sd4194304) >>> 23;
        if (yr > 45'sd32767)
        begin
            pipe_next[16].y = 16'sh7FFF;
        end
        else if (yr < -45'sd32768)
        begin
            pipe_next[16].y = 16'sh8000;
        end
        else
        begin
            pipe_next[16].y = 16'(yr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= item_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (en[S_ROM])
        begin
            va_reg <= SINE_ROM[pipe_reg[S_ROM-1].a];
            vb_reg <= (pipe_reg[S_ROM-1].a == AW'(SINE_ENTRIES - 1))
                ? SINE_ROM[0] : SINE_ROM[pipe_reg[S_ROM-1].a + AW'(1)];
        end
    end

`include "assert_macros.svh"

    `ASSERT_AT(a_full_when_blocked, clk, rst_n, !item_ready |-> (&v_reg))
    `ASSERT_AT(a_div_remainder, clk, rst_n, (v_reg[6] && pipe_reg[6].acta) |-> (pipe_reg[6].ra < pipe_reg[6].dt))
    `ASSERT_NEXT(a_request_enters, clk, rst_n, item_valid && item_ready, v_reg[0])

endmodule
